>>> sv/assert_macros.svh
// Assertion macros used by the port checker in sv/sncdf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check on clk, quiet in reset
`define CHK_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// next-cycle implication check
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`endif

>>> sv/sncdf_pkg.sv
// Package: constants and types of the sorted CDF builder.
package sncdf_pkg;
	localparam int MaxRowDef = 32;
	localparam int WeightBitsDef = 16;
	localparam int LenW = 6;
	localparam int IdxW = 5;
	localparam int CumW = 17;
	localparam int FracBits = 16;
	localparam logic [LenW-1:0] RowLenReset = 6'd32;

	typedef enum logic [2:0] {
		ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

>>> sv/sorted_normalized_cdf_builder_core.sv
// Top level: loads a row, insertion-sorts it, emits cumulative fractions.
//  channel | dir | signals
//  in      | in  | in_valid/in_ready, weight
//  out     | out | out_valid/out_ready, cum_value, entry_index, last_entry, zero_total
//  cfg     | in  | cfg_valid/cfg_ready, cfg_data (row_length)
// Loading: one word per cycle while in ST_LOAD. Sort: insertion sort over the store,
// each compare/shift step a read state then a compare state (registered memory read).
// Emit: one divide per entry, each followed by its output handshake.
// Reset clears control; store contents need none. Output stalls hold the sequencer.
module sorted_normalized_cdf_builder_core
	import sncdf_pkg::*;
#(
	parameter int MAX_ROW = MaxRowDef,
	parameter int WEIGHT_BITS = WeightBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [WEIGHT_BITS-1:0] weight,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [16:0]            cum_value,
	output logic [4:0]             entry_index,
	output logic                   last_entry,
	output logic                   zero_total,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [5:0]             cfg_data
);
	localparam int AW = $clog2(MAX_ROW);
	localparam int CNTW = $clog2(MAX_ROW + 1);
	localparam int TW = WEIGHT_BITS + CNTW;
	localparam int NW = TW + FracBits;

	logic [WEIGHT_BITS-1:0] wmem [MAX_ROW];
	logic [IdxW-1:0]        imem [MAX_ROW];
	logic [WEIGHT_BITS-1:0] rd_w_q;
	logic [IdxW-1:0]        rd_i_q;

	state_t state_q, state_d;
	logic [LenW-1:0] len_q;
	logic [CNTW-1:0] cnt_q, i_q, j_q, k_q;
	logic [TW-1:0]   tot_q, run_q;
	logic [WEIGHT_BITS-1:0] key_w_q;
	logic [IdxW-1:0] key_i_q;
	logic            out_v_q;
	logic [CumW-1:0] cum_q;
	logic [IdxW-1:0] eidx_q;
	logic            last_q, zero_q;
	logic            div_start, div_busy;
	logic [NW-1:0]   quo;

	logic [CNTW-1:0] eff_len, cnt_inc;
	logic            in_acc, we;
	logic [AW-1:0]   waddr, raddr;
	logic [WEIGHT_BITS-1:0] wdata;
	logic [IdxW-1:0] idata;
	logic            shift_ok;

	always_comb begin
		if (len_q == '0) eff_len = CNTW'(1);
		else if ({1'b0, len_q} > 7'(MAX_ROW)) eff_len = CNTW'(MAX_ROW);
		else eff_len = CNTW'(len_q);
	end

	assign in_acc = in_valid && in_ready;
	assign cnt_inc = (cnt_q < CNTW'(MAX_ROW)) ? cnt_q + 1'b1 : cnt_q;
	assign shift_ok = (j_q != '0) && (rd_w_q < key_w_q);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (in_acc && cnt_inc >= eff_len) state_d = ST_SORT_RD;
			ST_SORT_RD: begin
				if (i_q >= cnt_q) state_d = ST_DIV_START;
				else state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: state_d = ST_SORT_RD;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (!div_busy) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_v_q) begin
					if (k_q >= cnt_q) state_d = ST_LOAD;
					else state_d = ST_DIV_START;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// memory write port
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = weight;
		idata = '0;
		unique case (state_q)
			ST_LOAD: begin
				we = in_acc && (cnt_q < CNTW'(MAX_ROW));
				waddr = AW'(cnt_q);
				idata = IdxW'(cnt_q);
			end
			ST_SORT_CMP: begin
				we = 1'b1;
				waddr = AW'(j_q);
				if (shift_ok) begin
					wdata = rd_w_q;
					idata = rd_i_q;
				end else begin
					wdata = key_w_q;
					idata = key_i_q;
				end
			end
			default: ;
		endcase
	end

	// read address: previous slot during sort, entry 0 when the sort ends,
	// next entry when a word is issued, else entry k
	always_comb begin
		unique case (state_q)
			ST_SORT_RD: raddr = (i_q >= cnt_q) ? '0 : AW'(j_q - 1'b1);
			ST_EMIT:    raddr = out_v_q ? AW'(k_q) : AW'(k_q + 1'b1);
			default:    raddr = AW'(k_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wmem[waddr] <= wdata;
			imem[waddr] <= idata;
		end
		rd_w_q <= wmem[raddr];
		rd_i_q <= imem[raddr];
		// key of the insertion pass, read on its first compare
		if (state_q == ST_SORT_RD && j_q == i_q) begin
			key_w_q <= wmem[AW'(i_q)];
			key_i_q <= imem[AW'(i_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			len_q   <= RowLenReset;
			cnt_q   <= '0;
			tot_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			run_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) len_q <= cfg_data;
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CNTW'(MAX_ROW)) tot_q <= tot_q + TW'(weight);
						cnt_q <= cnt_inc;
						i_q <= CNTW'(1);
						j_q <= CNTW'(1);
					end
				end
				ST_SORT_RD: begin
					k_q <= '0;
					run_q <= '0;
				end
				ST_SORT_CMP: begin
					if (shift_ok) begin
						j_q <= j_q - 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + 1'b1;
					end
				end
				ST_DIV_START: run_q <= run_q + TW'(rd_w_q);
				ST_DIV_WAIT: ;
				ST_EMIT: begin
					if (!out_v_q) begin
						if (k_q >= cnt_q) begin
							cnt_q <= '0;
							tot_q <= '0;
						end else begin
							out_v_q <= 1'b1;
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	sncdf_div #(.NW(NW), .DW(TW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({run_q + TW'(rd_w_q), FracBits'(0)}),
		.den   (tot_q),
		.busy  (div_busy),
		.quo   (quo)
	);
	assign div_start = (state_q == ST_DIV_START);

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && !out_v_q && k_q < cnt_q) begin
			eidx_q <= rd_i_q;
			zero_q <= (tot_q == '0);
			cum_q  <= (tot_q == '0) ? '0 : CumW'(quo);
			last_q <= (k_q + 1'b1 == cnt_q);
		end
	end

	assign in_ready    = (state_q == ST_LOAD);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_v_q;
	assign cum_value   = cum_q;
	assign entry_index = eidx_q;
	assign last_entry  = last_q;
	assign zero_total  = zero_q;
endmodule

>>> sv/sncdf_div.sv
// Restoring divider, one quotient bit per cycle.
module sncdf_div #(
	parameter int NW = 38,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != '0);
	assign quo = q_q;
endmodule

>>> sv/sncdf_checker.sv
// Port checker for the sorted CDF builder, with its bind.
`include "assert_macros.svh"
module sncdf_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [16:0] cum_value,
	input logic last_entry,
	input logic zero_total
);
	`CHK_IMPL(a_no_overlap, out_valid, !in_ready)
	`CHK_IMPL(a_last_full, out_valid && last_entry && !zero_total, cum_value == 17'h10000)
	`CHK_IMPL(a_zero_val, out_valid && zero_total, cum_value == 17'd0)
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind sorted_normalized_cdf_builder_core sncdf_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cum_value(cum_value),
	.last_entry(last_entry), .zero_total(zero_total)
);

>>> tb/sncdf_checker.sv
// Checker: predicts sorted cumulative fractions per row and compares output words.
module sncdf_checker
	import sncdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] weight,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [16:0] cum_value,
	input  logic [4:0]  entry_index,
	input  logic        last_entry,
	input  logic        zero_total,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [16:0] cum;
		logic [4:0]  idx;
		logic        last;
		logic        zero;
	} cdf_word_t;

	cdf_word_t    cdf_expected[$];
	logic [5:0]   len_reg;
	logic [15:0]  row_w[MaxRowDef];
	logic [4:0]   row_i[MaxRowDef];
	int           loaded;
	logic [20:0]  total;

	assign pending = cdf_expected.size();

	function automatic int eff_len(logic [5:0] l);
		if (l == 0) return 1;
		if (l > MaxRowDef) return MaxRowDef;
		return l;
	endfunction

	task automatic load_weight(logic [15:0] w);
		logic [15:0] kw;
		logic [4:0]  ki;
		logic [37:0] run;
		cdf_word_t   e;
		int          j;
		if (loaded < MaxRowDef) begin
			row_w[loaded] = w;
			row_i[loaded] = loaded[4:0];
			loaded++;
			total += w;
		end
		if (loaded < eff_len(len_reg)) return;
		for (int i = 1; i < loaded; i++) begin
			kw = row_w[i];
			ki = row_i[i];
			j = i;
			while (j > 0 && row_w[j-1] < kw) begin
				row_w[j] = row_w[j-1];
				row_i[j] = row_i[j-1];
				j--;
			end
			row_w[j] = kw;
			row_i[j] = ki;
		end
		run = 0;
		for (int k = 0; k < loaded; k++) begin
			run += row_w[k];
			e.cum = (total == 0) ? '0 : 17'((run << 16) / total);
			e.idx = row_i[k];
			e.last = (k + 1 == loaded);
			e.zero = (total == 0);
			cdf_expected.push_back(e);
		end
		loaded = 0;
		total = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cdf_word_t e;
		if (!arst_n) begin
			len_reg <= RowLenReset;
			loaded = 0;
			total = 0;
			fail_count = 0;
			cdf_expected.delete();
		end else begin
			if (cfg_valid && cfg_ready) len_reg <= cfg_data;
			if (in_valid && in_ready) load_weight(weight);
			if (out_valid && out_ready) begin
				if (cdf_expected.size() == 0) begin
					$error("unexpected output word idx=%0d", entry_index);
					fail_count++;
				end else begin
					e = cdf_expected.pop_front();
					if (cum_value !== e.cum) begin
						$error("cum_value exp %0d got %0d", e.cum, cum_value);
						fail_count++;
					end
					if (entry_index !== e.idx) begin
						$error("entry_index exp %0d got %0d", e.idx, entry_index);
						fail_count++;
					end
					if (last_entry !== e.last) begin
						$error("last_entry exp %0d got %0d", e.last, last_entry);
						fail_count++;
					end
					if (zero_total !== e.zero) begin
						$error("zero_total exp %0d got %0d", e.zero, zero_total);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

>>> tb/tb_sorted_normalized_cdf_builder_core.sv
// Testbench top: weight stimulus, row length phases, output stalls and verdict.
module tb_sorted_normalized_cdf_builder_core;
	import sncdf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [15:0] weight = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [16:0] cum_value;
	logic [4:0]  entry_index;
	logic        last_entry;
	logic        zero_total;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          stall_mode = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	sorted_normalized_cdf_builder_core DUT (.*);

	sncdf_checker u_checker (.*);

	// receiver stall pattern, mode changes now and then
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int eff_rows(int l);
		if (l == 0) return 1;
		if (l > 32) return 32;
		return l;
	endfunction

	task automatic send_weight(logic [15:0] w);
		in_valid <= 1'b1;
		weight <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic end_burst();
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
		if (gap == 0) return;
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_len(logic [5:0] l);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= l;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_row(int n, int kind);
		int burst;
		logic [15:0] w;
		burst = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: w = 16'($urandom);
				1: w = 16'($urandom_range(0, 3));
				2: w = 16'hFFFF;
				default: w = '0;
			endcase
			send_weight(w);
			if (--burst == 0) begin
				end_burst();
				burst = $urandom_range(1, 8);
			end
		end
	endtask

	initial begin
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: single-weight rows, zero total, ties, extremes
		write_len(6'd1);
		send_weight(16'h0000);
		send_weight(16'hFFFF);
		send_weight(16'h0001);
		write_len(6'd0);
		send_weight(16'h8000);
		write_len(6'd4);
		send_row(4, 3);
		send_weight(16'd5); send_weight(16'd5); send_weight(16'd9); send_weight(16'd5);
		send_row(4, 2);
		send_weight(16'h5555); send_weight(16'hAAAA); send_weight(16'h0000);
		// length lowered mid-row: row completes on next weight
		write_len(6'd2);
		send_weight(16'd7);
		write_len(6'd63);
		send_row(32, 0);
		write_len(6'd32);
		send_row(32, 1);
		// random rows
		for (int r = 0; r < 7; r++) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 10);
			write_len(len[5:0]);
			send_row(eff_rows(len) * $urandom_range(1, 2), $urandom_range(0, 9) < 7 ? 0 :
				$urandom_range(1, 3));
		end
		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+sv
sv/sncdf_pkg.sv
sv/sncdf_div.sv
sv/sorted_normalized_cdf_builder_core.sv
sv/sncdf_checker.sv
tb/sncdf_checker.sv
tb/tb_sorted_normalized_cdf_builder_core.sv
